[sv/fbde_pkg.sv]
// ----------------------------------------------------------------------------
// fbde_pkg: shared types and constants
// Command codes, status codes, sequencer states and default image size
// for the frame buffer draw engine.
// ----------------------------------------------------------------------------
package fbde_pkg;

    localparam int DEF_IMAGE_WIDTH  = 512;
    localparam int DEF_IMAGE_HEIGHT = 512;

    localparam int COORD_W = 10;
    localparam int LIMIT_W = 13;

    localparam logic [7:0] PIX_MAX   = 8'd255;
    localparam logic [7:0] PIX_ZERO  = 8'd0;
    localparam logic [8:0] VALUE_MAX = 9'd255;

    typedef enum logic [2:0] {
        OP_RECT   = 3'd0,
        OP_SPAN   = 3'd1,
        OP_CROSS  = 3'd2,
        OP_THRESH = 3'd3,
        OP_WRITE  = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_VALUE = 2'd1,
        ST_BAD_COORD = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_CROSS,
        S_THRESH,
        S_READ
    } state_t;

endpackage

[sv/frame_buffer_draw_engine.sv]
// ----------------------------------------------------------------------------
// frame_buffer_draw_engine: 8-bit grey frame store with draw commands
// Pixel write, errors and unknown codes give their done beat without raising
// busy; pixel read, cross, fills and threshold hold busy until the done beat,
// which comes as busy falls.
// One pixel per cycle through the single store write port sets the fill rate.
// Reset clears the sequencer and result registers; the store is not cleared.
// ----------------------------------------------------------------------------
module frame_buffer_draw_engine #(
    parameter int IMAGE_WIDTH  = fbde_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = fbde_pkg::DEF_IMAGE_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] operation,
    input  logic [8:0] row_a,
    input  logic [8:0] col_a,
    input  logic [8:0] row_b,
    input  logic [8:0] col_b,
    input  logic [8:0] pixel_value,
    output logic       done,
    output logic [7:0] read_pixel,
    output logic [1:0] status
);

    localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    fbde_ctrl #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .DEPTH        (DEPTH),
        .AW           (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .row_a       (row_a),
        .col_a       (col_a),
        .row_b       (row_b),
        .col_b       (col_b),
        .pixel_value (pixel_value),
        .done        (done),
        .read_pixel  (read_pixel),
        .status      (status),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    fbde_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

[sv/fbde_mem.sv]
// ----------------------------------------------------------------------------
// fbde_mem: frame store
// Single write port, single read port, registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module fbde_mem #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/fbde_ctrl.sv]
// ----------------------------------------------------------------------------
// fbde_ctrl: command sequencer
// Checks each command except threshold, then walks its pixels one per cycle
// through a shared row-times-width address unit; threshold streams read-compare-write.
// ----------------------------------------------------------------------------
module fbde_ctrl #(
    parameter int IMAGE_WIDTH  = fbde_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = fbde_pkg::DEF_IMAGE_HEIGHT,
    parameter int DEPTH        = IMAGE_WIDTH * IMAGE_HEIGHT,
    parameter int AW           = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    operation,
    input  logic [8:0]    row_a,
    input  logic [8:0]    col_a,
    input  logic [8:0]    row_b,
    input  logic [8:0]    col_b,
    input  logic [8:0]    pixel_value,
    output logic          done,
    output logic [7:0]    read_pixel,
    output logic [1:0]    status,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    import fbde_pkg::*;

    localparam int PW = AW + COORD_W;
    localparam logic [LIMIT_W-1:0] H_LIM = LIMIT_W'(IMAGE_HEIGHT);
    localparam logic [LIMIT_W-1:0] W_LIM = LIMIT_W'(IMAGE_WIDTH);
    localparam logic [AW:0] N_END = (AW + 1)'(DEPTH);

    state_t state_reg, state_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] rhi_reg, rhi_next;
    logic [COORD_W-1:0] clo_reg, clo_next;
    logic [COORD_W-1:0] chi_reg, chi_next;
    logic [8:0] val_reg, val_next;
    logic [2:0] pt_reg, pt_next;
    logic [AW:0] px_reg, px_next;
    logic done_reg, done_next;
    logic [7:0] rpix_reg, rpix_next;
    logic [1:0] status_reg, status_next;

    logic [COORD_W-1:0] sel_row, sel_col;
    logic [AW-1:0] pix_addr;
    logic [COORD_W-1:0] in_ra, in_ca, in_rb, in_cb;
    logic accept;
    logic val_bad;
    logic rect_bad, span_bad, cross_bad, pt_bad;

    function automatic logic row_ok(input logic [COORD_W-1:0] r);
        return {3'b000, r} < H_LIM;
    endfunction

    function automatic logic col_ok(input logic [COORD_W-1:0] c);
        return {3'b000, c} < W_LIM;
    endfunction

    assign in_ra = {1'b0, row_a};
    assign in_ca = {1'b0, col_a};
    assign in_rb = {1'b0, row_b};
    assign in_cb = {1'b0, col_b};

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign val_bad   = pixel_value > VALUE_MAX;
    assign pt_bad    = !row_ok(in_ra) || !col_ok(in_ca);
    assign rect_bad  = pt_bad || !row_ok(in_rb) || !col_ok(in_cb);
    assign span_bad  = pt_bad || !col_ok(in_cb);
    assign cross_bad = (row_a == 9'd0) || (col_a == 9'd0)
                       || !row_ok(in_ra + COORD_W'(1)) || !col_ok(in_ca + COORD_W'(1));

    // shared address unit
    assign pix_addr = AW'(PW'(sel_row) * PW'(IMAGE_WIDTH) + PW'(sel_col));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            rpix_reg   <= PIX_ZERO;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            rpix_reg   <= rpix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        rhi_reg <= rhi_next;
        clo_reg <= clo_next;
        chi_reg <= chi_next;
        val_reg <= val_next;
        pt_reg  <= pt_next;
        px_reg  <= px_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        rhi_next    = rhi_reg;
        clo_next    = clo_reg;
        chi_next    = chi_reg;
        val_next    = val_reg;
        pt_next     = pt_reg;
        px_next     = px_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rpix_next   = rpix_reg;
        sel_row     = in_ra;
        sel_col     = in_ca;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = pix_addr;
        mem_raddr   = pix_addr;
        mem_wdata   = val_reg[7:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rpix_next = PIX_ZERO;
                    case (op_t'(operation))
                        OP_RECT, OP_SPAN:
                        begin
                            if (val_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_VALUE;
                            end
                            else if ((op_t'(operation) == OP_RECT) ? rect_bad : span_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_COORD;
                            end
                            else
                            begin
                                if (op_t'(operation) == OP_RECT && in_rb < in_ra)
                                begin
                                    row_next = in_rb;
                                    rhi_next = in_ra;
                                end
                                else if (op_t'(operation) == OP_RECT)
                                begin
                                    row_next = in_ra;
                                    rhi_next = in_rb;
                                end
                                else
                                begin
                                    row_next = in_ra;
                                    rhi_next = in_ra;
                                end
                                clo_next   = (in_cb < in_ca) ? in_cb : in_ca;
                                chi_next   = (in_cb < in_ca) ? in_ca : in_cb;
                                col_next   = (in_cb < in_ca) ? in_cb : in_ca;
                                val_next   = pixel_value;
                                state_next = S_FILL;
                            end
                        end
                        OP_CROSS:
                        begin
                            if (val_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_VALUE;
                            end
                            else if (cross_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_COORD;
                            end
                            else
                            begin
                                row_next   = in_ra;
                                col_next   = in_ca;
                                val_next   = pixel_value;
                                pt_next    = 3'd0;
                                state_next = S_CROSS;
                            end
                        end
                        OP_THRESH:
                        begin
                            val_next   = pixel_value;
                            px_next    = '0;
                            state_next = S_THRESH;
                        end
                        OP_WRITE:
                        begin
                            done_next = 1'b1;
                            if (val_bad)
                            begin
                                status_next = ST_BAD_VALUE;
                            end
                            else if (pt_bad)
                            begin
                                status_next = ST_BAD_COORD;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                mem_we      = 1'b1;
                                mem_wdata   = pixel_value[7:0];
                            end
                        end
                        OP_READ:
                        begin
                            if (pt_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_COORD;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                sel_row = row_reg;
                sel_col = col_reg;
                mem_we  = 1'b1;
                if (col_reg == chi_reg)
                begin
                    col_next = clo_reg;
                    if (row_reg == rhi_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + COORD_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COORD_W'(1);
                end
            end
            S_CROSS:
            begin
                case (pt_reg)
                    3'd0:
                    begin
                        sel_row = row_reg;
                        sel_col = col_reg;
                    end
                    3'd1:
                    begin
                        sel_row = row_reg - COORD_W'(1);
                        sel_col = col_reg - COORD_W'(1);
                    end
                    3'd2:
                    begin
                        sel_row = row_reg - COORD_W'(1);
                        sel_col = col_reg + COORD_W'(1);
                    end
                    3'd3:
                    begin
                        sel_row = row_reg + COORD_W'(1);
                        sel_col = col_reg - COORD_W'(1);
                    end
                    default:
                    begin
                        sel_row = row_reg + COORD_W'(1);
                        sel_col = col_reg + COORD_W'(1);
                    end
                endcase
                mem_we  = 1'b1;
                pt_next = pt_reg + 3'd1;
                if (pt_reg == 3'd4)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            S_THRESH:
            begin
                // read pixel n while writing back pixel n-1
                mem_raddr = px_reg[AW-1:0];
                mem_re    = (px_reg < N_END);
                mem_waddr = AW'(px_reg - (AW + 1)'(1));
                mem_we    = (px_reg != '0);
                mem_wdata = ({1'b0, mem_rdata} > val_reg) ? PIX_MAX : PIX_ZERO;
                px_next   = px_reg + (AW + 1)'(1);
                if (px_reg == N_END)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            S_READ:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                rpix_next   = mem_rdata;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done       = done_reg;
    assign read_pixel = rpix_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation == OP_READ && !pt_bad |=> busy && !done)
        else $error("read did not hold busy for the data cycle");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> read_pixel == PIX_ZERO)
        else $error("failed command returned pixel data");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && !busy |-> accept && operation == OP_WRITE)
        else $error("store written while idle without a pixel write");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != 2'd3)
        else $error("undefined status code");
`endif

endmodule
